>>> rtl/afs_pkg.sv
// Shared constants, codes and types for the animation frame sequencer.
package afs_pkg;

  // Width of the integer frame part of the position.
  localparam int FRAME_BITS = 16;
  // Position is unsigned Q(FRAME_BITS).16.
  localparam int POS_W      = FRAME_BITS + 16;
  // Signed working width for the position arithmetic: holds the sum of a
  // position, a step and a range length, with room for the sign.
  localparam int CALC_W     = POS_W + 2;

  localparam int SPEED_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic signed [SPEED_W-1:0] SPEED_RESET = 16'sd6144;
  localparam logic signed [SPEED_W-1:0] SPEED_MIN   = -16'sd32768;
  localparam logic signed [SPEED_W-1:0] SPEED_MAX   = 16'sd32767;

  // Command codes carried on the mode field.
  typedef enum logic [2:0] {
    MODE_TICK   = 3'd0,
    MODE_START  = 3'd1,
    MODE_STOP   = 3'd2,
    MODE_PAUSE  = 3'd3,
    MODE_RESUME = 3'd4
  } mode_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_FRAME   = 3'd0,
    REG_END_FRAME     = 3'd1,
    REG_INITIAL_SPEED = 3'd2,
    REG_PLAY_FLAGS    = 3'd3,
    REG_EVENT_ENABLE  = 3'd4
  } cfg_reg_t;

  // Bit positions in play_flags.
  localparam int FLAG_LOOP     = 0;
  localparam int FLAG_PINGPONG = 1;

endpackage

>>> rtl/animation_frame_sequencer.sv
// Animation frame sequencer: command-driven frame position playback.
//
// Usage: each input beat on in_* is one command (tick, start, stop, pause,
// resume); every command gives exactly one result beat on out_*. A beat is
// taken when valid is high and stall is low. Configuration registers
// (range, initial speed, play flags, event enable) are written through
// cfg_* (cfg_ready is always high); the user must write them only while
// no command is in flight, which the block does not enforce; the values
// are used live by the next command. Two register stages (command
// register, result register) sit in the path. Throughput: one command
// per cycle while out_stall is low. The tick multiply, the bound compare
// and the wrap/clamp are combinational between those two registers, and
// the playback state is written back when the result register loads, so
// the next command sees it at once.
// Reset (rst_n low, synchronous): position 0, speed 6144 (24 fps Q8.8),
// inactive, not running; registers go to their documented reset values.
// Receiver stall: the result register holds; an empty command register
// still takes one more beat, then in_stall rises until the result drains.
module animation_frame_sequencer (
  input  logic                              clk,
  input  logic                              rst_n,
  // command channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [2:0]                        in_mode,
  input  logic [15:0]                       in_time_step,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [31:0]                       out_frame_position,
  output logic [15:0]                       out_current_frame,
  output logic [15:0]                       out_next_frame,
  output logic                              out_is_active,
  output logic                              out_is_running,
  output logic                              out_frame_changed,
  output logic                              out_started,
  output logic                              out_stopped,
  // configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [afs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [afs_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import afs_pkg::*;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [15:0]                start_frame_r;
  logic [15:0]                end_frame_r;
  logic signed [SPEED_W-1:0]  initial_speed_r;
  logic [1:0]                 play_flags_r;
  logic                       event_enable_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_frame_r   <= '0;
      end_frame_r     <= '0;
      initial_speed_r <= SPEED_RESET;
      play_flags_r    <= '0;
      event_enable_r  <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_START_FRAME:   start_frame_r   <= cfg_data[15:0];
        REG_END_FRAME:     end_frame_r     <= cfg_data[15:0];
        REG_INITIAL_SPEED: initial_speed_r <= $signed(cfg_data[15:0]);
        REG_PLAY_FLAGS:    play_flags_r    <= cfg_data[1:0];
        REG_EVENT_ENABLE:  event_enable_r  <= cfg_data[0];
        default: ;  // writes beyond the list are dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Handshake: command register -> result register
  // ---------------------------------------------------------------------
  logic        in_valid_r;
  logic [2:0]  in_mode_r;
  logic [15:0] in_time_step_r;
  logic        out_valid_r;

  logic        in_take;   // command beat accepted
  logic        out_adv;   // result register may load
  logic        exec;      // command register executes this cycle

  assign out_adv  = !out_valid_r || !out_stall;
  assign in_stall = in_valid_r && !out_adv;
  assign in_take  = in_valid && !in_stall;
  assign exec     = in_valid_r && out_adv;
  assign out_valid = out_valid_r;

  // ---------------------------------------------------------------------
  // Playback state
  // ---------------------------------------------------------------------
  logic [POS_W-1:0]          pos_r,     pos_nxt;
  logic signed [SPEED_W-1:0] speed_r,   speed_nxt;
  logic                      active_r,  active_nxt;
  logic                      running_r, running_nxt;
  logic                      bounced_r, bounced_nxt;
  logic                      started_nxt, stopped_nxt;

  // range bounds, masked to the frame width
  logic [FRAME_BITS-1:0] s_f, e_f, lo_f, hi_f;
  logic                  same_bounds;
  logic                  is_loop, is_pong;

  assign s_f         = FRAME_BITS'(start_frame_r);
  assign e_f         = FRAME_BITS'(end_frame_r);
  assign lo_f        = (e_f > s_f) ? s_f : e_f;
  assign hi_f        = (e_f > s_f) ? e_f : s_f;
  assign same_bounds = (s_f == e_f);
  assign is_loop     = play_flags_r[FLAG_LOOP];
  assign is_pong     = play_flags_r[FLAG_PINGPONG];

  // tick step: (|speed| * time_step) >> 8
  logic [SPEED_W-1:0] speed_mag;
  logic [31:0]        step_prod;
  logic [23:0]        step;

  assign speed_mag = speed_r[SPEED_W-1] ? (~speed_r + 16'd1) : speed_r;
  assign step_prod = 32'(speed_mag) * 32'(in_time_step_r);
  assign step      = step_prod[31:8];

  logic signed [CALC_W-1:0] pos_s, step_s, plo_s, phi_s, p_inc, p_dec, p_sel;
  logic                     hit_hi, hit_lo;
  logic                     tick_ok;

  assign pos_s  = $signed(CALC_W'(pos_r));
  assign step_s = $signed(CALC_W'(step));
  assign plo_s  = $signed(CALC_W'({lo_f, 16'h0000}));
  assign phi_s  = $signed(CALC_W'({hi_f, 16'h0000}));
  assign p_inc  = pos_s + step_s;
  assign p_dec  = pos_s - step_s;
  assign hit_hi = (p_inc >= phi_s);
  assign hit_lo = (p_dec <= plo_s);
  assign tick_ok = running_r && !same_bounds && (speed_r != '0);

  // speed reversal saturates the most negative value
  logic signed [SPEED_W-1:0] speed_neg;
  assign speed_neg = (speed_r == SPEED_MIN) ? SPEED_MAX : -speed_r;

  always_comb begin
    pos_nxt     = pos_r;
    speed_nxt   = speed_r;
    active_nxt  = active_r;
    running_nxt = running_r;
    bounced_nxt = bounced_r;
    started_nxt = 1'b0;
    stopped_nxt = 1'b0;
    p_sel       = pos_s;

    case (in_mode_r)
      MODE_TICK: begin
        if (tick_ok) begin
          if (!speed_r[SPEED_W-1]) begin
            p_sel = p_inc;
          end else begin
            p_sel = p_dec;
          end
          if ((!speed_r[SPEED_W-1] && hit_hi) || (speed_r[SPEED_W-1] && hit_lo)) begin
            if (is_pong) begin
              p_sel = speed_r[SPEED_W-1] ? plo_s : phi_s;
              if (is_loop || !bounced_r) begin
                speed_nxt   = speed_neg;
                bounced_nxt = 1'b1;
              end else if (active_r) begin
                active_nxt  = 1'b0;
                running_nxt = 1'b0;
                stopped_nxt = 1'b1;
              end
            end else if (is_loop) begin
              // single wrap by the range length
              p_sel = speed_r[SPEED_W-1] ? (p_dec + (phi_s - plo_s))
                                         : (p_inc - (phi_s - plo_s));
            end else begin
              p_sel = speed_r[SPEED_W-1] ? plo_s : phi_s;
              if (active_r) begin
                active_nxt  = 1'b0;
                running_nxt = 1'b0;
                stopped_nxt = 1'b1;
              end
            end
          end
          // saturate to 0 .. 2^POS_W-1
          if (p_sel[CALC_W-1]) begin
            pos_nxt = '0;
          end else if (p_sel[POS_W]) begin
            pos_nxt = '1;
          end else begin
            pos_nxt = p_sel[POS_W-1:0];
          end
        end
      end
      MODE_START: begin
        active_nxt  = 1'b1;
        running_nxt = 1'b1;
        speed_nxt   = initial_speed_r;
        bounced_nxt = 1'b0;
        pos_nxt     = {s_f, 16'h0000};
        started_nxt = 1'b1;
      end
      MODE_STOP: begin
        if (active_r) begin
          active_nxt  = 1'b0;
          running_nxt = 1'b0;
          stopped_nxt = 1'b1;
        end
      end
      MODE_PAUSE: begin
        running_nxt = 1'b0;
      end
      MODE_RESUME: begin
        if (!same_bounds) begin
          running_nxt = 1'b1;
        end
      end
      default: ;  // unused codes only report status
    endcase
  end

  // ---------------------------------------------------------------------
  // Frame reporting from the updated state
  // ---------------------------------------------------------------------
  logic [FRAME_BITS-1:0] f_int, cur_f, nxt_f;
  logic [FRAME_BITS:0]   f_inc;

  assign f_int = pos_nxt[POS_W-1:16];
  assign f_inc = {1'b0, f_int} + 1'b1;

  always_comb begin
    // current frame: integer part plus one when playing backwards, capped at hi
    if (!speed_nxt[SPEED_W-1]) begin
      cur_f = f_int;
    end else if (f_inc > {1'b0, hi_f}) begin
      cur_f = hi_f;
    end else begin
      cur_f = f_inc[FRAME_BITS-1:0];
    end

    // next frame in the direction of travel
    if (same_bounds) begin
      nxt_f = s_f;
    end else if (!speed_nxt[SPEED_W-1]) begin
      if (f_inc > {1'b0, hi_f}) begin
        if (is_pong) begin
          nxt_f = (is_loop || !bounced_nxt) ? (hi_f - 1'b1) : hi_f;
        end else if (is_loop) begin
          nxt_f = lo_f;
        end else begin
          nxt_f = hi_f;
        end
      end else begin
        nxt_f = f_inc[FRAME_BITS-1:0];
      end
    end else begin
      if (f_int < lo_f) begin
        if (is_pong) begin
          nxt_f = (is_loop || !bounced_nxt) ? (lo_f + 1'b1) : lo_f;
        end else if (is_loop) begin
          nxt_f = hi_f;
        end else begin
          nxt_f = lo_f;
        end
      end else begin
        nxt_f = f_int;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pos_r       <= '0;
      speed_r     <= SPEED_RESET;
      active_r    <= 1'b0;
      running_r   <= 1'b0;
      bounced_r   <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_r <= 1'b1;
      end else if (exec) begin
        in_valid_r <= 1'b0;
      end
      if (out_adv) begin
        out_valid_r <= in_valid_r;
      end
      if (exec) begin
        pos_r     <= pos_nxt;
        speed_r   <= speed_nxt;
        active_r  <= active_nxt;
        running_r <= running_nxt;
        bounced_r <= bounced_nxt;
      end
    end
  end

  // command and result payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_mode_r      <= in_mode;
      in_time_step_r <= in_time_step;
    end
    if (exec) begin
      out_frame_position <= 32'(pos_nxt);
      out_current_frame  <= 16'(cur_f);
      out_next_frame     <= 16'(nxt_f);
      out_is_active      <= active_nxt;
      out_is_running     <= running_nxt;
      out_frame_changed  <= (pos_nxt != pos_r) && event_enable_r;
      out_started        <= started_nxt;
      out_stopped        <= stopped_nxt;
    end
  end

endmodule
